// ===== design/pvbs_pkg.sv =====
package pvbs_pkg;

    // default transform length of the surrounding stft
    localparam int TRANSFORM_SIZE_DEF = 2048;

    // cordic iteration count for both modes
    localparam int CORDIC_STEPS = 24;

    // inverse cordic gain in q30
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

    // output saturation limits
    localparam logic signed [28:0] OUT_MAX = 29'sh0FFF_FFFF;
    localparam logic signed [28:0] OUT_MIN = 29'sh1000_0000;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int unsigned i);
        logic [31:0] r;
        case (i)
            0:       r = 32'd536870912;
            1:       r = 32'd316933406;
            2:       r = 32'd167458907;
            3:       r = 32'd85004756;
            4:       r = 32'd42667331;
            5:       r = 32'd21354465;
            6:       r = 32'd10679838;
            7:       r = 32'd5340245;
            8:       r = 32'd2670163;
            9:       r = 32'd1335087;
            10:      r = 32'd667544;
            11:      r = 32'd333772;
            12:      r = 32'd166886;
            13:      r = 32'd83443;
            14:      r = 32'd41722;
            15:      r = 32'd20861;
            16:      r = 32'd10430;
            17:      r = 32'd5215;
            18:      r = 32'd2608;
            19:      r = 32'd1304;
            20:      r = 32'd652;
            21:      r = 32'd326;
            22:      r = 32'd163;
            23:      r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/pvbs_ram.sv =====
module pvbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1025
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/phase_vocoder_bin_step.sv =====
// phase vocoder bin step: one spectral bin per beat
// input channel: in_valid / in_stall with the left and right frame bins,
// the blend fraction and the reset-phase flag; a beat is taken when
// in_valid is high and in_stall is low
// output channel: out_valid / out_stall with bin_number, synth_real and
// synth_imag, one result beat for every input beat, in order
// throughput: one beat per cycle while in_stall is low; every unit (square root, both cordic
// engines, phase store read-modify-write) is a fully pipelined stage chain
// the path from input beat to output register runs through the 28-stage
// square root, the blend, the phase store stage and the 24-stage rotator
// the phase store read-modify-write forwards between back-to-back beats
// of the same bin, so any bin order is allowed
// reset: after rst_n is released in_stall stays high while the phase store
// is swept to zero
// stall: a stalled result sits in the output register and one more beat in
// a skid register; the pipeline then freezes and in_stall rises
module phase_vocoder_bin_step #(
    parameter int TRANSFORM_SIZE = pvbs_pkg::TRANSFORM_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [10:0]        bin_index,
    input  logic signed [27:0] left_real,
    input  logic signed [27:0] left_imag,
    input  logic signed [27:0] right_real,
    input  logic signed [27:0] right_imag,
    input  logic [15:0]        blend_fraction,
    input  logic               reset_phase,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [10:0]        bin_number,
    output logic signed [28:0] synth_real,
    output logic signed [28:0] synth_imag
);

    localparam int BIN_COUNT = TRANSFORM_SIZE / 2 + 1;
    localparam int ADDR_W    = $clog2(BIN_COUNT);
    localparam int BIN_W     = (ADDR_W > 11) ? ADDR_W : 11;
    localparam int LAST      = 60;

    logic en;
    logic clearing_reg;
    logic [ADDR_W-1:0] clear_cnt_reg;
    logic [LAST:0] v_reg;

    // carried fields
    logic [10:0] bin_reg [0:LAST];
    logic        inr_reg [0:LAST];
    logic [15:0] frac_reg [0:30];
    logic        rst_reg [0:32];

    // input stage
    logic signed [27:0] lr_reg, li_reg, rr_reg, ri_reg;

    // squares and sums
    logic signed [55:0] sq_lr_reg, sq_li_reg, sq_rr_reg, sq_ri_reg;

    // square root chains
    logic [55:0] sn_l_reg [2:30];
    logic [29:0] srem_l_reg [2:30];
    logic [27:0] sroot_l_reg [2:30];
    logic [55:0] sn_r_reg [2:30];
    logic [29:0] srem_r_reg [2:30];
    logic [27:0] sroot_r_reg [2:30];

    // vectoring cordic chains
    logic signed [63:0] vx_l_reg [1:25];
    logic signed [63:0] vy_l_reg [1:25];
    logic [31:0]        vz_l_reg [1:25];
    logic               vzero_l_reg [1:25];
    logic signed [63:0] vx_r_reg [1:25];
    logic signed [63:0] vy_r_reg [1:25];
    logic [31:0]        vz_r_reg [1:25];
    logic               vzero_r_reg [1:25];

    // phases
    logic [15:0] phl_reg [26:32];
    logic [15:0] phr_reg;
    logic [15:0] d_reg [27:32];

    // blend
    logic [44:0] wl_reg, wr_reg;
    logic [27:0] amp_reg [32:33];
    logic [45:0] blend_sum;

    // phase store
    logic [ADDR_W-1:0] ram_raddr, ram_waddr;
    logic [BIN_W-1:0]  bin_a_wide, bin_b_wide;
    logic [15:0]       ram_rdata, ram_wdata, ph_cur, ph_new;
    logic              ram_we, store_we;
    logic              fwd_hit_reg;
    logic [15:0]       fwd_val_reg;
    logic [15:0]       ph_syn_reg;

    // rotation cordic
    logic [57:0]        gain_prod;
    logic signed [33:0] a_init;
    logic signed [63:0] rx_reg [34:58];
    logic signed [63:0] ry_reg [34:58];
    logic signed [33:0] ra_reg [34:58];
    logic               neg_reg [34:59];
    logic signed [33:0] rnd_x_reg, rnd_y_reg;
    logic signed [28:0] sx_reg, sy_reg;

    // output register and skid
    logic               out_valid_reg, skid_valid_reg;
    logic [10:0]        out_bin_reg, skid_bin_reg;
    logic signed [28:0] out_re_reg, out_im_reg, skid_re_reg, skid_im_reg;
    logic               take, pipe_out;
    logic               out_valid_next, skid_valid_next;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg | clearing_reg;

    // phase store clearing sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clear_cnt_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == ADDR_W'(BIN_COUNT - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAST-1:0], in_valid & ~clearing_reg};
        end
    end

    // input beat and carried fields
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bin_reg[0]  <= bin_index;
            inr_reg[0]  <= ({21'd0, bin_index} < 32'(BIN_COUNT));
            frac_reg[0] <= blend_fraction;
            rst_reg[0]  <= reset_phase;
            lr_reg      <= left_real;
            li_reg      <= left_imag;
            rr_reg      <= right_real;
            ri_reg      <= right_imag;
            for (int t = 1; t <= LAST; t++)
            begin
                bin_reg[t] <= bin_reg[t-1];
                inr_reg[t] <= inr_reg[t-1];
            end
            for (int t = 1; t <= 30; t++)
            begin
                frac_reg[t] <= frac_reg[t-1];
            end
            for (int t = 1; t <= 32; t++)
            begin
                rst_reg[t] <= rst_reg[t-1];
            end
        end
    end

    // squares, vectoring start, sums of squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_lr_reg <= lr_reg * lr_reg;
            sq_li_reg <= li_reg * li_reg;
            sq_rr_reg <= rr_reg * rr_reg;
            sq_ri_reg <= ri_reg * ri_reg;

            vzero_l_reg[1] <= (lr_reg == '0) && (li_reg == '0);
            vzero_r_reg[1] <= (rr_reg == '0) && (ri_reg == '0);
            if (lr_reg < 0)
            begin
                vx_l_reg[1] <= -{{4{lr_reg[27]}}, lr_reg, 32'd0};
                vy_l_reg[1] <= -{{4{li_reg[27]}}, li_reg, 32'd0};
                vz_l_reg[1] <= 32'h8000_0000;
            end
            else
            begin
                vx_l_reg[1] <= {{4{lr_reg[27]}}, lr_reg, 32'd0};
                vy_l_reg[1] <= {{4{li_reg[27]}}, li_reg, 32'd0};
                vz_l_reg[1] <= 32'd0;
            end
            if (rr_reg < 0)
            begin
                vx_r_reg[1] <= -{{4{rr_reg[27]}}, rr_reg, 32'd0};
                vy_r_reg[1] <= -{{4{ri_reg[27]}}, ri_reg, 32'd0};
                vz_r_reg[1] <= 32'h8000_0000;
            end
            else
            begin
                vx_r_reg[1] <= {{4{rr_reg[27]}}, rr_reg, 32'd0};
                vy_r_reg[1] <= {{4{ri_reg[27]}}, ri_reg, 32'd0};
                vz_r_reg[1] <= 32'd0;
            end

            sn_l_reg[2]    <= $unsigned(sq_lr_reg) + $unsigned(sq_li_reg);
            sn_r_reg[2]    <= $unsigned(sq_rr_reg) + $unsigned(sq_ri_reg);
            srem_l_reg[2]  <= '0;
            srem_r_reg[2]  <= '0;
            sroot_l_reg[2] <= '0;
            sroot_r_reg[2] <= '0;
        end
    end

    // square root, one result bit per stage
    for (genvar t = 3; t <= 30; t++)
    begin : g_sqrt
        logic [29:0] rem_l, trial_l, rem_r, trial_r;

        always_comb
        begin
            rem_l   = {srem_l_reg[t-1][27:0], sn_l_reg[t-1][55:54]};
            trial_l = {sroot_l_reg[t-1], 2'b01};
            rem_r   = {srem_r_reg[t-1][27:0], sn_r_reg[t-1][55:54]};
            trial_r = {sroot_r_reg[t-1], 2'b01};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sn_l_reg[t] <= {sn_l_reg[t-1][53:0], 2'b00};
                sn_r_reg[t] <= {sn_r_reg[t-1][53:0], 2'b00};
                if (rem_l >= trial_l)
                begin
                    srem_l_reg[t]  <= rem_l - trial_l;
                    sroot_l_reg[t] <= {sroot_l_reg[t-1][26:0], 1'b1};
                end
                else
                begin
                    srem_l_reg[t]  <= rem_l;
                    sroot_l_reg[t] <= {sroot_l_reg[t-1][26:0], 1'b0};
                end
                if (rem_r >= trial_r)
                begin
                    srem_r_reg[t]  <= rem_r - trial_r;
                    sroot_r_reg[t] <= {sroot_r_reg[t-1][26:0], 1'b1};
                end
                else
                begin
                    srem_r_reg[t]  <= rem_r;
                    sroot_r_reg[t] <= {sroot_r_reg[t-1][26:0], 1'b0};
                end
            end
        end
    end

    // vectoring cordic, one micro-rotation per stage
    for (genvar t = 2; t <= 25; t++)
    begin : g_vec
        localparam int I = t - 2;
        localparam logic [31:0] ATAN = pvbs_pkg::atan_turn(I);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vzero_l_reg[t] <= vzero_l_reg[t-1];
                vzero_r_reg[t] <= vzero_r_reg[t-1];
                if (vy_l_reg[t-1] < 0)
                begin
                    vx_l_reg[t] <= vx_l_reg[t-1] - (vy_l_reg[t-1] >>> I);
                    vy_l_reg[t] <= vy_l_reg[t-1] + (vx_l_reg[t-1] >>> I);
                    vz_l_reg[t] <= vz_l_reg[t-1] - ATAN;
                end
                else
                begin
                    vx_l_reg[t] <= vx_l_reg[t-1] + (vy_l_reg[t-1] >>> I);
                    vy_l_reg[t] <= vy_l_reg[t-1] - (vx_l_reg[t-1] >>> I);
                    vz_l_reg[t] <= vz_l_reg[t-1] + ATAN;
                end
                if (vy_r_reg[t-1] < 0)
                begin
                    vx_r_reg[t] <= vx_r_reg[t-1] - (vy_r_reg[t-1] >>> I);
                    vy_r_reg[t] <= vy_r_reg[t-1] + (vx_r_reg[t-1] >>> I);
                    vz_r_reg[t] <= vz_r_reg[t-1] - ATAN;
                end
                else
                begin
                    vx_r_reg[t] <= vx_r_reg[t-1] + (vy_r_reg[t-1] >>> I);
                    vy_r_reg[t] <= vy_r_reg[t-1] - (vx_r_reg[t-1] >>> I);
                    vz_r_reg[t] <= vz_r_reg[t-1] + ATAN;
                end
            end
        end
    end

    // phase rounding, phase difference, blend
    assign blend_sum = 46'(wl_reg) + 46'(wr_reg) + 46'd32768;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phl_reg[26] <= vzero_l_reg[25] ? 16'd0 : 16'((vz_l_reg[25] + 32'h8000) >> 16);
            phr_reg     <= vzero_r_reg[25] ? 16'd0 : 16'((vz_r_reg[25] + 32'h8000) >> 16);
            for (int t = 27; t <= 32; t++)
            begin
                phl_reg[t] <= phl_reg[t-1];
            end
            d_reg[27] <= phr_reg - phl_reg[26];
            for (int t = 28; t <= 32; t++)
            begin
                d_reg[t] <= d_reg[t-1];
            end
            wl_reg      <= (17'd65536 - 17'(frac_reg[30])) * sroot_l_reg[30];
            wr_reg      <= frac_reg[30] * sroot_r_reg[30];
            amp_reg[32] <= blend_sum[43:16];
            amp_reg[33] <= amp_reg[32];
        end
    end

    // phase store read-modify-write: read for the beat entering, update at stage 32
    assign bin_a_wide = BIN_W'(bin_reg[31]);
    assign bin_b_wide = BIN_W'(bin_reg[32]);
    assign ram_raddr  = en ? bin_a_wide[ADDR_W-1:0] : bin_b_wide[ADDR_W-1:0];
    assign ph_cur     = rst_reg[32] ? phl_reg[32] : (fwd_hit_reg ? fwd_val_reg : ram_rdata);
    assign ph_new     = ph_cur + d_reg[32];
    assign store_we   = en & v_reg[32] & inr_reg[32];
    assign ram_we     = clearing_reg | store_we;
    assign ram_waddr  = clearing_reg ? clear_cnt_reg : bin_b_wide[ADDR_W-1:0];
    assign ram_wdata  = clearing_reg ? 16'd0 : ph_new;

    pvbs_ram #(
        .WIDTH (16),
        .DEPTH (BIN_COUNT)
    ) u_phase_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // forward the update to a following beat of the same bin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (en)
        begin
            fwd_hit_reg <= v_reg[31] & inr_reg[31] & v_reg[32] & inr_reg[32]
                           & (bin_reg[31] == bin_reg[32]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fwd_val_reg <= ph_new;
            ph_syn_reg  <= ph_cur;
        end
    end

    // rotator start: gain-scaled amplitude and angle folded to a half turn
    assign gain_prod = amp_reg[33] * pvbs_pkg::INV_GAIN_Q30;
    assign a_init    = 34'($signed({ph_syn_reg, 16'd0}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg[34] <= $signed(64'(gain_prod));
            ry_reg[34] <= '0;
            if (a_init > 34'sd1073741824)
            begin
                ra_reg[34]  <= a_init - 34'sd2147483648;
                neg_reg[34] <= 1'b1;
            end
            else if (a_init < -34'sd1073741824)
            begin
                ra_reg[34]  <= a_init + 34'sd2147483648;
                neg_reg[34] <= 1'b1;
            end
            else
            begin
                ra_reg[34]  <= a_init;
                neg_reg[34] <= 1'b0;
            end
            for (int t = 35; t <= 59; t++)
            begin
                neg_reg[t] <= neg_reg[t-1];
            end
        end
    end

    // rotation cordic, one micro-rotation per stage
    for (genvar t = 35; t <= 58; t++)
    begin : g_rot
        localparam int I = t - 35;
        localparam logic signed [33:0] ATAN = $signed(34'(pvbs_pkg::atan_turn(I)));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (ra_reg[t-1] >= 0)
                begin
                    rx_reg[t] <= rx_reg[t-1] - (ry_reg[t-1] >>> I);
                    ry_reg[t] <= ry_reg[t-1] + (rx_reg[t-1] >>> I);
                    ra_reg[t] <= ra_reg[t-1] - ATAN;
                end
                else
                begin
                    rx_reg[t] <= rx_reg[t-1] + (ry_reg[t-1] >>> I);
                    ry_reg[t] <= ry_reg[t-1] - (rx_reg[t-1] >>> I);
                    ra_reg[t] <= ra_reg[t-1] + ATAN;
                end
            end
        end
    end

    // round from q30, then negate, saturate and blank out-of-range bins
    logic signed [63:0] rsum_x, rsum_y;
    logic signed [34:0] fx, fy;

    assign rsum_x = rx_reg[58] + 64'sd536870912;
    assign rsum_y = ry_reg[58] + 64'sd536870912;
    assign fx     = neg_reg[59] ? -35'(rnd_x_reg) : 35'(rnd_x_reg);
    assign fy     = neg_reg[59] ? -35'(rnd_y_reg) : 35'(rnd_y_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnd_x_reg <= 34'(rsum_x >>> 30);
            rnd_y_reg <= 34'(rsum_y >>> 30);
            if (!inr_reg[59])
            begin
                sx_reg <= '0;
            end
            else if (fx > 35'(pvbs_pkg::OUT_MAX))
            begin
                sx_reg <= pvbs_pkg::OUT_MAX;
            end
            else if (fx < 35'(pvbs_pkg::OUT_MIN))
            begin
                sx_reg <= pvbs_pkg::OUT_MIN;
            end
            else
            begin
                sx_reg <= fx[28:0];
            end
            if (!inr_reg[59])
            begin
                sy_reg <= '0;
            end
            else if (fy > 35'(pvbs_pkg::OUT_MAX))
            begin
                sy_reg <= pvbs_pkg::OUT_MAX;
            end
            else if (fy < 35'(pvbs_pkg::OUT_MIN))
            begin
                sy_reg <= pvbs_pkg::OUT_MIN;
            end
            else
            begin
                sy_reg <= fy[28:0];
            end
        end
    end

    // output register with skid
    assign take     = out_valid_reg & ~out_stall;
    assign pipe_out = v_reg[LAST] & en;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (pipe_out)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_next = 1'b1;
            end
            out_valid_next = 1'b1;
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_bin_reg <= skid_bin_reg;
                out_re_reg  <= skid_re_reg;
                out_im_reg  <= skid_im_reg;
            end
        end
        else if (pipe_out)
        begin
            if (out_valid_reg && !take)
            begin
                skid_bin_reg <= bin_reg[LAST];
                skid_re_reg  <= sx_reg;
                skid_im_reg  <= sy_reg;
            end
            else
            begin
                out_bin_reg <= bin_reg[LAST];
                out_re_reg  <= sx_reg;
                out_im_reg  <= sy_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign bin_number = out_bin_reg;
    assign synth_real = out_re_reg;
    assign synth_imag = out_im_reg;

    // no beat is taken during the clearing sweep
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> in_stall)
        else $error("beat could enter during phase store clearing");

    // no pipeline write can collide with the clearing sweep
    a_clear_no_store: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !v_reg[32])
        else $error("phase store update during clearing");

    // skid only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output register is empty");

    // a forward hit always belongs to a live beat at the update stage
    a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> v_reg[32])
        else $error("phase forward without a beat at the update stage");

    // bins beyond the spectrum give zero output
    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ({21'd0, out_bin_reg} >= 32'(BIN_COUNT)))
        |-> (out_re_reg == '0) && (out_im_reg == '0))
        else $error("out-of-range bin gave nonzero output");

endmodule
